FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion violated");

// Consequent that must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion violated");

`endif

FILE: rtl/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg
// Types, constants and elaboration helpers of the size class block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package scba_pkg;

  localparam int unsigned IDX_W       = 12;
  localparam int unsigned BONE_W      = 8;
  localparam int unsigned CLASS_LIMIT = 10;
  localparam int unsigned CLS_W       = $clog2(CLASS_LIMIT);
  localparam int unsigned RUN_W       = 9;
  localparam int unsigned SIZE_W      = 9;

  localparam int unsigned DEF_BLOCK_BONES = 4;
  localparam int unsigned DEF_MAX_BONES   = 64;
  localparam int unsigned DEF_HEAP_BLOCKS = 4096;
  localparam int unsigned DEF_STACK_DEPTH = 64;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_SPACE   = 2'd1,
    STATUS_STACK_FULL = 2'd2
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_e;

  typedef struct packed {
    cmd_e              command;
    logic [BONE_W-1:0] bone_count;
    logic [IDX_W-1:0]  block_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    status_e          status;
    logic             fresh;
  } out_item_t;

  typedef struct packed {
    cmd_e             command;
    logic [CLS_W-1:0] cls;
    logic [RUN_W-1:0] run;
    logic [IDX_W-1:0] index;
  } op_t;

  function automatic int unsigned scba_num_classes(int unsigned block, int unsigned maxb);
    int unsigned size;
    int unsigned cnt;
    size = block;
    cnt  = 1;
    for (int unsigned j = 0; j + 1 < CLASS_LIMIT; j++) begin
      if (size < maxb) begin
        size = size * 2;
        if (size > maxb) begin
          size = maxb;
        end
        cnt = cnt + 1;
      end
    end
    return cnt;
  endfunction

  function automatic int unsigned scba_class_size(int unsigned block, int unsigned maxb,
                                                  int unsigned k);
    int unsigned size;
    size = block;
    for (int unsigned j = 0; j < CLASS_LIMIT; j++) begin
      if (j < k && size < maxb) begin
        size = size * 2;
        if (size > maxb) begin
          size = maxb;
        end
      end
    end
    return size;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/scba_ram.sv
// ----------------------------------------------------------------------------
// scba_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/scba_fifo.sv
// ----------------------------------------------------------------------------
// scba_fifo
// Short queue of classified operations between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_fifo import scba_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire op_t  wdata_i,
  output logic      full_o,
  input  wire logic rd_i,
  output op_t       rdata_o,
  output logic      valid_o
);

  op_t               entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_i) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_i) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entries_q[wptr_q] <= wdata_i;
    end
  end

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = entries_q[rptr_q];

endmodule

`default_nettype wire

FILE: rtl/scba_front.sv
// ----------------------------------------------------------------------------
// scba_front
// Accepts requests, maps the bone count to a size class and run length,
// and hands the classified operation to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_front import scba_pkg::*; #(
  parameter int unsigned BLOCK_BONES = DEF_BLOCK_BONES,
  parameter int unsigned MAX_BONES   = DEF_MAX_BONES,
  parameter int unsigned NUM_CLASSES = scba_num_classes(DEF_BLOCK_BONES, DEF_MAX_BONES)
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          q_wr_o,
  output op_t           q_wdata_o,
  input  wire logic     q_full_i
);

  logic [SIZE_W-1:0] size_c [NUM_CLASSES];
  logic [RUN_W-1:0]  run_c  [NUM_CLASSES];

  for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_cls
    localparam int unsigned Size = scba_class_size(BLOCK_BONES, MAX_BONES, k);
    localparam int unsigned Run  = (Size / BLOCK_BONES == 0) ? 1 : Size / BLOCK_BONES;
    assign size_c[k] = SIZE_W'(Size);
    assign run_c[k]  = RUN_W'(Run);
  end

  logic             vld_q, vld_d;
  op_t              op_q, op_d;
  logic             load;
  logic [CLS_W-1:0] cls;
  logic [RUN_W-1:0] run;

  always_comb begin
    cls = CLS_W'(NUM_CLASSES - 1);
    run = run_c[NUM_CLASSES-1];
    for (int k = int'(NUM_CLASSES) - 2; k >= 0; k--) begin
      if (SIZE_W'(in_data_i.bone_count) <= size_c[k]) begin
        cls = CLS_W'(k);
        run = run_c[k];
      end
    end
  end

  assign q_wr_o     = vld_q && !q_full_i;
  assign in_stall_o = vld_q && q_full_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = load || (vld_q && !q_wr_o);
    op_d  = op_q;
    if (load) begin
      op_d.command = in_data_i.command;
      op_d.cls     = cls;
      op_d.run     = run;
      op_d.index   = in_data_i.block_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign q_wdata_o = op_q;

endmodule

`default_nettype wire

FILE: rtl/scba_back.sv
// ----------------------------------------------------------------------------
// scba_back
// Executes classified operations: per-class free stacks in RAM, stack
// counts, heap top, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module scba_back import scba_pkg::*; #(
  parameter int unsigned HEAP_BLOCKS = DEF_HEAP_BLOCKS,
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned NUM_CLASSES = scba_num_classes(DEF_BLOCK_BONES, DEF_MAX_BONES)
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic op_valid_i,
  input  wire op_t  op_i,
  output logic      op_pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned CntW     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned HeapW    = $clog2(HEAP_BLOCKS + 1);
  localparam int unsigned SumW     = ((HeapW > RUN_W) ? HeapW : RUN_W) + 1;
  localparam int unsigned MemDepth = NUM_CLASSES * STACK_DEPTH;
  localparam int unsigned AddrW    = $clog2(MemDepth);

  back_state_e      state_q, state_d;
  logic [CntW-1:0]  cnt_q [CLASS_LIMIT];
  logic [CntW-1:0]  cnt_d [CLASS_LIMIT];
  logic [HeapW-1:0] heap_q, heap_d;
  logic             out_vld_q, out_vld_d;
  out_item_t        out_q, out_d;

  logic [CntW-1:0]  cur_cnt;
  logic [AddrW-1:0] base;
  logic [SumW-1:0]  heap_sum;
  logic             no_space;
  logic             slot_free;
  logic             start;
  logic             out_load;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [IDX_W-1:0] ram_rdata;

  assign cur_cnt   = cnt_q[op_i.cls];
  assign base      = AddrW'(op_i.cls) * AddrW'(STACK_DEPTH);
  assign heap_sum  = SumW'(heap_q) + SumW'(op_i.run);
  assign no_space  = heap_sum > SumW'(HEAP_BLOCKS);
  assign slot_free = !out_vld_q || !out_stall_i;
  assign start     = (state_q == BK_IDLE) && op_valid_i && slot_free;
  assign op_pop_o  = start;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (start && op_i.command == CMD_ALLOC && cur_cnt != '0) begin
          state_d = BK_READ;
        end
      end
      BK_READ: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    heap_d    = heap_q;
    out_d     = out_q;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = base + AddrW'(cur_cnt);
    ram_raddr = base + AddrW'(cur_cnt - 1'b1);
    unique case (state_q)
      BK_IDLE: begin
        if (start) begin
          out_d.result_index = '0;
          out_d.status       = STATUS_OK;
          out_d.fresh        = 1'b0;
          unique case (op_i.command)
            CMD_ALLOC: begin
              if (cur_cnt != '0) begin
                cnt_d[op_i.cls] = cur_cnt - 1'b1;
                ram_re          = 1'b1;
              end else if (no_space) begin
                out_d.status = STATUS_NO_SPACE;
                out_load     = 1'b1;
              end else begin
                out_d.result_index = IDX_W'(heap_q);
                out_d.fresh        = 1'b1;
                heap_d             = HeapW'(heap_sum);
                out_load           = 1'b1;
              end
            end
            CMD_FREE: begin
              if (cur_cnt == CntW'(STACK_DEPTH)) begin
                out_d.status = STATUS_STACK_FULL;
              end else begin
                cnt_d[op_i.cls] = cur_cnt + 1'b1;
                ram_we          = 1'b1;
              end
              out_load = 1'b1;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        out_d.result_index = ram_rdata;
        out_d.status       = STATUS_OK;
        out_d.fresh        = 1'b0;
        out_load           = 1'b1;
      end
      default: ;
    endcase
    out_vld_d = out_load || (out_vld_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      heap_q    <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < CLASS_LIMIT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      heap_q    <= heap_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  scba_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MemDepth)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (op_i.index),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPLIES(a_read_slot_empty, state_q == BK_READ, !out_vld_q && !op_pop_o)
  `ASSERT_ALWAYS(a_heap_in_range, heap_q <= HeapW'(HEAP_BLOCKS))
  `ASSERT_IMPLIES(a_count_in_range, op_valid_i, cur_cnt <= CntW'(STACK_DEPTH))

endmodule

`default_nettype wire

FILE: rtl/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Hands out and takes back runs of heap blocks by power-of-two size class.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one request per
// transaction, allocate or release, with a bone count and, on release, the
// first block of the run. Output channel (out_valid_o / out_stall_i /
// out_data_o): exactly one result per request, in request order.
// A result passes the front register, the queue and the result register;
// an allocation served from a class free stack also waits for its stack
// RAM read. Up to one request per cycle is sustained while the receiver
// does not stall and no stack-served allocation waits in BK_READ.
// Reset clears all stack counts, the heap top and every valid flag; the
// stack RAM holds no reset state and needs no clearing. While the receiver
// stalls, the result register holds and the front keeps accepting until
// its register and the 2-entry queue fill, then raises in_stall_o.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_block_allocator import scba_pkg::*; #(
  parameter int unsigned BLOCK_BONES = DEF_BLOCK_BONES,
  parameter int unsigned MAX_BONES   = DEF_MAX_BONES,
  parameter int unsigned HEAP_BLOCKS = DEF_HEAP_BLOCKS,
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  localparam int unsigned NumClasses = scba_num_classes(BLOCK_BONES, MAX_BONES);

  logic q_wr, q_full, q_rd, q_valid;
  op_t  q_wdata, q_rdata;

  scba_front #(
    .BLOCK_BONES (BLOCK_BONES),
    .MAX_BONES   (MAX_BONES),
    .NUM_CLASSES (NumClasses)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_wr_o     (q_wr),
    .q_wdata_o  (q_wdata),
    .q_full_i   (q_full)
  );

  scba_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .valid_o (q_valid)
  );

  scba_back #(
    .HEAP_BLOCKS (HEAP_BLOCKS),
    .STACK_DEPTH (STACK_DEPTH),
    .NUM_CLASSES (NumClasses)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_rdata),
    .op_pop_o    (q_rd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
